### src/rtp_h264_depacketizer_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RTP H.264 depacketizer
// ---------------------------------------------------------------------------
`ifndef RTP_H264_DEPACKETIZER_CORE_MACROS_SVH
`define RTP_H264_DEPACKETIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RHD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rhd_pkg.sv
// ---------------------------------------------------------------------------
// rhd_pkg
// Shared types and constants of the RTP H.264 depacketizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rhd_pkg;

  localparam logic [7:0] START_CODE_TAIL   = 8'h01;
  localparam logic [4:0] MAX_SINGLE_TYPE   = 5'd23;
  localparam logic [4:0] STAP_A_TYPE       = 5'd24;
  localparam logic [4:0] FU_A_TYPE         = 5'd28;
  localparam logic [6:0] RTP_FIXED_HDR_LEN = 7'd12;
  localparam int         QUEUE_DEPTH       = 4;

  // One request from the parser: optional abandon notice, optional start
  // code, optional data result.
  typedef struct packed {
    logic       drop;
    logic [4:0] drop_kind;
    logic       start;
    logic       emit;
    logic [7:0] data;
    logic       data_valid;
    logic [4:0] kind;
    logic       last;
  } cmd_t;

endpackage

`default_nettype wire

### src/rhd_front.sv
// ---------------------------------------------------------------------------
// rhd_front
// Packet parser: skips the RTP header, classifies the payload and turns each
// byte into at most one request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic          q_full,
  input  wire logic [7:0]    in_byte,
  input  wire logic          pkt_last,
  output rhd_pkg::cmd_t      cmd,
  output logic               cmd_push
);
  import rhd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR, PH_IND, PH_SINGLE, PH_STAPHI, PH_STAPLO, PH_UNIT, PH_FU, PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [6:0]  header_count, header_count_next;
  logic [3:0]  csrc_count, csrc_count_next;
  logic [2:0]  indicator_bits, indicator_bits_next;
  logic        nal_open, nal_open_next;
  logic [4:0]  open_type, open_type_next;
  logic [15:0] stap_remaining, stap_remaining_next;
  logic [1:0]  fragment_role, fragment_role_next;

  logic        accept;
  logic [6:0]  hdr_limit;
  logic [4:0]  pt;
  logic        unit_end;

  assign accept = push && !q_full;
  assign pt     = in_byte[4:0];

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    csrc_count_next     = csrc_count;
    indicator_bits_next = indicator_bits;
    nal_open_next       = nal_open;
    open_type_next      = open_type;
    stap_remaining_next = stap_remaining;
    fragment_role_next  = fragment_role;
    cmd                 = '0;
    hdr_limit           = RTP_FIXED_HDR_LEN;
    unit_end            = 1'b0;

    if (accept) begin
      unique case (phase)
        PH_HDR: begin
          if (header_count == '0) csrc_count_next = in_byte[3:0];
          header_count_next = header_count + 7'd1;
          hdr_limit = RTP_FIXED_HDR_LEN + {1'b0, csrc_count_next, 2'b00};
          if (header_count_next >= hdr_limit) phase_next = PH_IND;
        end
        PH_IND: begin
          indicator_bits_next = in_byte[7:5];
          if (pt == FU_A_TYPE) begin
            fragment_role_next = 2'd0;
            phase_next = PH_FU;
          end else begin
            // every other type closes out an open FU NAL
            cmd.drop      = nal_open;
            cmd.drop_kind = open_type;
            nal_open_next = 1'b0;
            if (pt <= MAX_SINGLE_TYPE) begin
              open_type_next = pt;
              cmd.start      = 1'b1;
              cmd.emit       = 1'b1;
              cmd.data       = in_byte;
              cmd.data_valid = 1'b1;
              cmd.kind       = pt;
              cmd.last       = pkt_last;
              phase_next     = PH_SINGLE;
            end else if (pt == STAP_A_TYPE) begin
              phase_next = PH_STAPHI;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SINGLE: begin
          cmd.emit       = 1'b1;
          cmd.data       = in_byte;
          cmd.data_valid = 1'b1;
          cmd.kind       = open_type;
          cmd.last       = pkt_last;
        end
        PH_STAPHI: begin
          stap_remaining_next = {in_byte, 8'h00};
          phase_next = PH_STAPLO;
        end
        PH_STAPLO: begin
          stap_remaining_next = {stap_remaining[15:8], in_byte};
          fragment_role_next  = 2'd0;
          phase_next = (stap_remaining_next != '0) ? PH_UNIT : PH_SKIP;
        end
        PH_UNIT: begin
          stap_remaining_next = stap_remaining - 16'd1;
          unit_end = (stap_remaining_next == '0) || pkt_last;
          cmd.emit       = 1'b1;
          cmd.data       = in_byte;
          cmd.data_valid = 1'b1;
          cmd.last       = unit_end;
          if (fragment_role == 2'd0) begin
            open_type_next     = pt;
            cmd.start          = 1'b1;
            cmd.kind           = pt;
            fragment_role_next = 2'd1;
          end else begin
            cmd.kind = open_type;
          end
          if (stap_remaining_next == '0) phase_next = PH_SKIP;
        end
        PH_FU: begin
          if (fragment_role == 2'd0) begin
            if (in_byte[7]) begin
              cmd.drop           = nal_open;
              cmd.drop_kind      = open_type;
              open_type_next     = pt;
              nal_open_next      = 1'b1;
              cmd.start          = 1'b1;
              cmd.emit           = 1'b1;
              cmd.data           = {indicator_bits, pt};
              cmd.data_valid     = 1'b1;
              cmd.kind           = pt;
              fragment_role_next = 2'd1;
            end else if (!nal_open) begin
              phase_next = PH_SKIP;
            end else if (in_byte[6]) begin
              if (pkt_last) begin
                // empty end fragment: close with a dataless result
                cmd.emit      = 1'b1;
                cmd.kind      = open_type;
                cmd.last      = 1'b1;
                nal_open_next = 1'b0;
              end else begin
                fragment_role_next = 2'd2;
              end
            end else begin
              fragment_role_next = 2'd1;
            end
          end else begin
            unit_end       = (fragment_role == 2'd2) && pkt_last;
            cmd.emit       = 1'b1;
            cmd.data       = in_byte;
            cmd.data_valid = 1'b1;
            cmd.kind       = open_type;
            cmd.last       = unit_end;
            if (unit_end) nal_open_next = 1'b0;
          end
        end
        PH_SKIP: begin
        end
        default: begin
        end
      endcase

      if (pkt_last) begin
        phase_next        = PH_HDR;
        header_count_next = '0;
      end
    end
  end

  assign cmd_push = accept && (cmd.drop || cmd.emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR;
      header_count   <= '0;
      csrc_count     <= '0;
      indicator_bits <= '0;
      nal_open       <= 1'b0;
      open_type      <= '0;
      stap_remaining <= '0;
      fragment_role  <= '0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      csrc_count     <= csrc_count_next;
      indicator_bits <= indicator_bits_next;
      nal_open       <= nal_open_next;
      open_type      <= open_type_next;
      stap_remaining <= stap_remaining_next;
      fragment_role  <= fragment_role_next;
    end
  end

endmodule

`default_nettype wire

### src/rhd_fifo.sv
// ---------------------------------------------------------------------------
// rhd_fifo
// Request queue between the parser and the result sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhd_fifo #(
  parameter int Depth = rhd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  rhd_pkg::cmd_t      wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output rhd_pkg::cmd_t      rd_data,
  output logic               empty
);
  import rhd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full    = (count == DepthCnt);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      if (do_wr && !do_rd)      count <= count + CntW'(1);
      else if (do_rd && !do_wr) count <= count - CntW'(1);
    end
  end

endmodule

`default_nettype wire

### src/rhd_back.sv
// ---------------------------------------------------------------------------
// rhd_back
// Result sequencer: expands each request into abandon notice, start code and
// data results into the output register, one per cycle unless it is held.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rhd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  rhd_pkg::cmd_t      head,
  input  wire logic          q_empty,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic [4:0]         nal_kind,
  output logic               first_of_nal,
  output logic               last_of_nal,
  output logic               abandon,
  output logic               run_last
);
  import rhd_pkg::*;

  typedef enum logic [2:0] {
    ST_DROP, ST_SC0, ST_SC1, ST_SC2, ST_SC3, ST_DATA
  } step_t;

  step_t      step, cur, nxt;
  logic       busy;
  logic       out_valid;
  logic       advance;
  logic       fin;
  logic [7:0] r_byte;
  logic       r_valid, r_first, r_last, r_abandon;
  logic [4:0] r_kind;

  always_comb begin
    if (busy)           cur = step;
    else if (head.drop) cur = ST_DROP;
    else if (head.start) cur = ST_SC0;
    else                cur = ST_DATA;

    r_byte    = 8'h00;
    r_valid   = 1'b1;
    r_kind    = head.kind;
    r_first   = 1'b0;
    r_last    = 1'b0;
    r_abandon = 1'b0;
    nxt       = ST_DATA;
    fin       = 1'b0;

    unique case (cur)
      ST_DROP: begin
        r_valid   = 1'b0;
        r_kind    = head.drop_kind;
        r_abandon = 1'b1;
        if (head.start)     nxt = ST_SC0;
        else if (head.emit) nxt = ST_DATA;
        else                fin = 1'b1;
      end
      ST_SC0: begin
        r_first = 1'b1;
        nxt     = ST_SC1;
      end
      ST_SC1: nxt = ST_SC2;
      ST_SC2: nxt = ST_SC3;
      ST_SC3: begin
        r_byte = START_CODE_TAIL;
        nxt    = ST_DATA;
      end
      ST_DATA: begin
        r_byte  = head.data;
        r_valid = head.data_valid;
        r_last  = head.last;
        fin     = 1'b1;
      end
      default: fin = 1'b1;
    endcase
  end

  // hold the output register until taken; refill in the same cycle as pop
  assign advance = !q_empty && (!out_valid || pop);
  assign q_pop   = advance && fin;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      step      <= ST_DROP;
    end else begin
      if (advance) begin
        out_valid    <= 1'b1;
        busy         <= !fin;
        step         <= nxt;
        out_byte     <= r_byte;
        byte_valid   <= r_valid;
        nal_kind     <= r_kind;
        first_of_nal <= r_first;
        last_of_nal  <= r_last;
        abandon      <= r_abandon;
        run_last     <= fin;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/rtp_h264_depacketizer_core.sv
// ---------------------------------------------------------------------------
// rtp_h264_depacketizer_core
// RTP H.264 depacketizer: RTP packet bytes in, Annex B bytes out.
// ---------------------------------------------------------------------------
// Input side: a queue write port. Present in_byte and pkt_last with push;
// the byte is taken on a clock edge with push high and full low.
// Output side: a queue read port. While empty is low the oldest result sits
// on out_byte, byte_valid, nal_kind, first_of_nal, last_of_nal, abandon and
// run_last; pop with empty low takes it.
// The parser takes one byte per cycle while full is low and writes at most
// one request into a QueueDepth-entry request queue. The sequencer turns a
// request into one to six results (abandon notice, four start code bytes,
// NAL byte), one per cycle while the output register is free or popped. A
// byte with one result passes the request queue, then the output register;
// a NAL start holds the sequencer through its start code and NAL byte, after
// any abandon notice. Payload bytes pass at one byte per cycle while the
// receiver pops; full also rises when start code bursts outrun the queue.
// When the receiver stalls, the output register holds and the queue fills,
// then full rises. Reset clears the queue, the output register and the
// parser state; the parser then expects the first byte of an RTP header.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rtp_h264_depacketizer_core_macros.svh"

module rtp_h264_depacketizer_core #(
  parameter int QueueDepth = rhd_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       pkt_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic [4:0]      nal_kind,
  output logic            first_of_nal,
  output logic            last_of_nal,
  output logic            abandon,
  output logic            run_last
);
  import rhd_pkg::*;

  cmd_t cmd, head;
  logic cmd_push, q_full, q_empty, q_pop;

  assign full = q_full;

  rhd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .q_full   (q_full),
    .in_byte  (in_byte),
    .pkt_last (pkt_last),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  rhd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  rhd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .nal_kind     (nal_kind),
    .first_of_nal (first_of_nal),
    .last_of_nal  (last_of_nal),
    .abandon      (abandon),
    .run_last     (run_last)
  );

  `RHD_ASSERT_IMP(a_abandon_bare, !empty && abandon, !byte_valid && !first_of_nal && !last_of_nal && out_byte == 8'h00, "abandon notice carries data or NAL marks")
  `RHD_ASSERT_IMP(a_first_is_zero, !empty && first_of_nal, byte_valid && out_byte == 8'h00 && !run_last && !abandon, "first start code byte malformed")
  `RHD_ASSERT_NEXT(a_drain, !empty && pop && q_empty, empty, "result appeared with no request queued")

endmodule

`default_nettype wire

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb: RTP H.264 depacketizer testbench
// Feeds RTP packets byte by byte (single NAL, STAP-A, FU-A sequences, other
// types, cut packets and noise) and checks every Annex B result against a
// scoreboard that tracks its own copy of the parser state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rhd_pkg::*;

  typedef enum logic [2:0] {
    PH_RTP_HDR, PH_NAL_HDR, PH_SINGLE, PH_STAP_HI, PH_STAP_LO, PH_STAP_UNIT,
    PH_FU, PH_SKIP
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [4:0] kind;
    logic       first;
    logic       lastnal;
    logic       drop;
    logic       run_end;
  } annexb_t;

  class annexb_scoreboard;
    parse_phase_t phase;
    logic [6:0]   hdr_cnt;
    logic [3:0]   csrc_cnt;
    logic [2:0]   nri_bits;
    logic         nal_open;
    logic [4:0]   open_kind;
    logic [15:0]  stap_left;
    logic [1:0]   frag_role;
    annexb_t      byte_results[$];
    annexb_t      expected_annexb[$];
    int           errors;

    function new();
      phase     = PH_RTP_HDR;
      hdr_cnt   = '0;
      csrc_cnt  = '0;
      nri_bits  = '0;
      nal_open  = 1'b0;
      open_kind = '0;
      stap_left = '0;
      frag_role = '0;
      errors    = 0;
    endfunction

    function void emit(logic [7:0] d, logic v, logic [4:0] k, logic f, logic l,
                       logic a);
      annexb_t r;
      r = '{data: d, valid: v, kind: k, first: f, lastnal: l, drop: a,
            run_end: 1'b0};
      byte_results.push_back(r);
    endfunction

    function void emit_start(logic [4:0] k, logic [7:0] hdr, logic l);
      emit(8'h00, 1'b1, k, 1'b1, 1'b0, 1'b0);
      emit(8'h00, 1'b1, k, 1'b0, 1'b0, 1'b0);
      emit(8'h00, 1'b1, k, 1'b0, 1'b0, 1'b0);
      emit(START_CODE_TAIL, 1'b1, k, 1'b0, 1'b0, 1'b0);
      emit(hdr, 1'b1, k, 1'b0, l, 1'b0);
    endfunction

    // Announce the discard of an FU NAL left open.
    function void drop_open();
      if (nal_open) begin
        emit(8'h00, 1'b0, open_kind, 1'b0, 1'b0, 1'b1);
        nal_open = 1'b0;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      logic [4:0] t;
      logic       fin;
      byte_results.delete();
      case (phase)
        PH_RTP_HDR: begin
          if (hdr_cnt == 0) csrc_cnt = b[3:0];
          hdr_cnt = hdr_cnt + 7'd1;
          if (hdr_cnt >= RTP_FIXED_HDR_LEN + {1'b0, csrc_cnt, 2'b00}) phase = PH_NAL_HDR;
        end
        PH_NAL_HDR: begin
          t = b[4:0];
          nri_bits = b[7:5];
          if (t <= MAX_SINGLE_TYPE) begin
            drop_open();
            open_kind = t;
            emit_start(t, b, l);
            phase = PH_SINGLE;
          end else if (t == STAP_A_TYPE) begin
            drop_open();
            phase = PH_STAP_HI;
          end else if (t == FU_A_TYPE) begin
            frag_role = 2'd0;
            phase = PH_FU;
          end else begin
            drop_open();
            phase = PH_SKIP;
          end
        end
        PH_SINGLE: emit(b, 1'b1, open_kind, 1'b0, l, 1'b0);
        PH_STAP_HI: begin
          stap_left = {b, 8'h00};
          phase = PH_STAP_LO;
        end
        PH_STAP_LO: begin
          stap_left = stap_left | {8'h00, b};
          frag_role = 2'd0;
          phase = (stap_left != 0) ? PH_STAP_UNIT : PH_SKIP;
        end
        PH_STAP_UNIT: begin
          stap_left = stap_left - 16'd1;
          fin = (stap_left == 0) || l;
          if (frag_role == 0) begin
            open_kind = b[4:0];
            emit_start(open_kind, b, fin);
            frag_role = 2'd1;
          end else begin
            emit(b, 1'b1, open_kind, 1'b0, fin, 1'b0);
          end
          if (stap_left == 0) phase = PH_SKIP;
        end
        PH_FU: begin
          if (frag_role == 0) begin
            // FU header: S, E, R, type
            if (b[7]) begin
              drop_open();
              open_kind = b[4:0];
              nal_open = 1'b1;
              emit_start(b[4:0], {nri_bits, b[4:0]}, 1'b0);
              frag_role = 2'd1;
            end else if (!nal_open) begin
              phase = PH_SKIP;
            end else if (b[6]) begin
              if (l) begin
                emit(8'h00, 1'b0, open_kind, 1'b0, 1'b1, 1'b0);
                nal_open = 1'b0;
              end else begin
                frag_role = 2'd2;
              end
            end else begin
              frag_role = 2'd1;
            end
          end else begin
            fin = (frag_role == 2) && l;
            emit(b, 1'b1, open_kind, 1'b0, fin, 1'b0);
            if (fin) nal_open = 1'b0;
          end
        end
        default: ;
      endcase
      if (l) begin
        phase = PH_RTP_HDR;
        hdr_cnt = '0;
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_end = 1'b1;
      foreach (byte_results[i]) expected_annexb.push_back(byte_results[i]);
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(annexb_t act);
      annexb_t exp_r;
      if (expected_annexb.size() == 0) begin
        $display("%0t: unexpected result out_byte %0h kind %0h", $time, act.data, act.kind);
        errors++;
        return;
      end
      exp_r = expected_annexb.pop_front();
      check_field("out_byte", exp_r.data, act.data);
      check_field("byte_valid", exp_r.valid, act.valid);
      check_field("nal_kind", exp_r.kind, act.kind);
      check_field("first_of_nal", exp_r.first, act.first);
      check_field("last_of_nal", exp_r.lastnal, act.lastnal);
      check_field("abandon", exp_r.drop, act.drop);
      check_field("run_last", exp_r.run_end, act.run_end);
    endfunction

    function int pending();
      return expected_annexb.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       pkt_last = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [4:0] nal_kind;
  logic       first_of_nal;
  logic       last_of_nal;
  logic       abandon;
  logic       run_last;

  logic [7:0]       pkt_bytes[$];
  logic             calm = 1'b0;
  logic             fu_in_flight = 1'b0;
  annexb_scoreboard annexb_check;

  rtp_h264_depacketizer_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .pkt_last(pkt_last), .empty(empty), .pop(pop), .out_byte(out_byte),
    .byte_valid(byte_valid), .nal_kind(nal_kind), .first_of_nal(first_of_nal),
    .last_of_nal(last_of_nal), .abandon(abandon), .run_last(run_last)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic l, input logic gaps);
    if (gaps && !calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    push     <= 1'b1;
    in_byte  <= b;
    pkt_last <= l;
    do @(posedge clk); while (full);
    annexb_check.note_byte(b, l);
    @(negedge clk);
  endtask

  task automatic send_packet();
    logic gaps;
    gaps = ($urandom_range(0, 9) < 7);
    foreach (pkt_bytes[i]) push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, gaps);
  endtask

  task automatic add_random_bytes(input int unsigned n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic build_packet();
    logic [3:0]  csrc;
    logic        s;
    logic        e;
    logic [4:0]  t;
    int unsigned pick;
    int unsigned n;
    pkt_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 92) begin
      // noise: a short run of random bytes
      add_random_bytes($urandom_range(1, 20));
      return;
    end
    csrc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    pkt_bytes.push_back({4'($urandom_range(0, 15)), csrc});
    add_random_bytes(11 + 4 * int'(csrc));
    if (pick < 25) begin
      t = 5'($urandom_range(0, int'(MAX_SINGLE_TYPE)));
      pkt_bytes.push_back({3'($urandom_range(0, 7)), t});
      add_random_bytes($urandom_range(0, 5));
      fu_in_flight = 1'b0;
    end else if (pick < 40) begin
      pkt_bytes.push_back({3'($urandom_range(0, 7)), STAP_A_TYPE});
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = $urandom_range(256, 65535);
        default: n = $urandom_range(1, 6);
      endcase
      pkt_bytes.push_back(8'(n >> 8));
      pkt_bytes.push_back(8'(n));
      add_random_bytes($urandom_range(0, 8));
      fu_in_flight = 1'b0;
    end else if (pick < 85) begin
      // FU-A: mostly start, middle, end in order; some orphans and restarts
      n = $urandom_range(0, 19);
      if (!fu_in_flight ? (n < 17) : (n < 2)) begin
        s = 1'b1;
        e = (n == 0);
      end else begin
        s = 1'b0;
        e = 1'($urandom_range(0, 1));
      end
      pkt_bytes.push_back({3'($urandom_range(0, 7)), FU_A_TYPE});
      pkt_bytes.push_back({s, e, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31))});
      add_random_bytes((e && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
      if (s) fu_in_flight = 1'b1;
      else if (e) fu_in_flight = 1'b0;
    end else begin
      n = 25 + $urandom_range(0, 5);
      if (n >= int'(FU_A_TYPE)) n = n + 1;
      pkt_bytes.push_back({3'($urandom_range(0, 7)), 5'(n)});
      add_random_bytes($urandom_range(0, 4));
      fu_in_flight = 1'b0;
    end
    // cut the packet short now and then
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
    end
  endtask

  initial begin
    int rand_sent;
    annexb_check = new();
    rand_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single NAL with F/NRI set, payload extremes
    pkt_bytes = '{8'h80, 8'h7F, 8'h00, 8'h01, 8'hFF, 8'hAA, 8'h55, 8'h12, 8'h34,
                  8'h56, 8'h78, 8'h9A, 8'hE5, 8'h00, 8'hFF};
    send_packet();
    // packet cut inside the header, then a short run of noise
    pkt_bytes = '{8'h8F, 8'h33};
    send_packet();
    pkt_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    send_packet();

    while (rand_sent < 270) begin
      build_packet();
      calm = (rand_sent > 210);
      send_packet();
      rand_sent += pkt_bytes.size();
    end
    push <= 1'b0;

    calm = 1'b1;
    while (annexb_check.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (annexb_check.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: pop in runs, stall in bursts.
  initial begin
    int      stall_left;
    int      run_left;
    annexb_t act;
    stall_left = 0;
    run_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall_left == 0 && run_left == 0) begin
        if (!calm && $urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 15);
        else run_left = $urandom_range(1, 40);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        run_left--;
      end
      @(posedge clk);
      if (pop && !empty) begin
        act = '{data: out_byte, valid: byte_valid, kind: nal_kind, first: first_of_nal,
                lastnal: last_of_nal, drop: abandon, run_end: run_last};
        annexb_check.check_result(act);
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
